[hdl/tpws_pkg.sv]
// Shared types and constants for the tuner PLL register-word sequencer.
`default_nettype none

package tpws_pkg;

    localparam int FREQ_W  = 22;
    localparam int BW_W    = 16;
    localparam int QUOT_W  = 16;
    localparam int CNT_W   = 13;
    localparam int LPF_W   = 4;
    localparam int WAIT_W  = 4;
    localparam int COUNT_W = 3;

    typedef logic [7:0] byte_t;

    // Register words after the frequency and bandwidth have been folded in
    typedef struct packed {
        byte_t w1;
        byte_t w2;
        byte_t w3;
        byte_t w4;
    } words_t;

    // Write slots of one sequence, in emission order
    localparam logic [1:0] BEAT_VCO     = 2'd0;
    localparam logic [1:0] BEAT_TM      = 2'd1;
    localparam logic [1:0] BEAT_FINAL   = 2'd2;
    localparam logic [1:0] BEAT_RESTORE = 2'd3;

    localparam byte_t W1_INIT = 8'h44;
    localparam byte_t W3_INIT = 8'hE1;
    localparam byte_t W4_INIT = 8'h42;

    localparam logic [FREQ_W-1:0] REF_SPLIT_KHZ = FREQ_W'(1024000);

    localparam byte_t MASK_CP_HI  = 8'hBF;
    localparam byte_t MASK_CP_LO  = 8'hDF;
    localparam byte_t MASK_VCO_W1 = 8'h9F;
    localparam byte_t SET_VCO_W1  = 8'h20;
    localparam byte_t MASK_W3     = 8'hE3;
    localparam byte_t MASK_W4     = 8'hF3;
    localparam byte_t TM_BIT      = 8'h04;

    localparam logic [WAIT_W-1:0]  WAIT_TM_MS = 4'd12;
    localparam logic [WAIT_W-1:0]  WAIT_NONE  = 4'd0;
    localparam logic [COUNT_W-1:0] COUNT_FULL = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_PAIR = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 3'd1;

    // floor(f/50) = (f*RECIP_STEP) >> 28, floor(f/100) = (f*RECIP_STEP) >> 29
    localparam int RECIP_STEP_W = 23;
    localparam logic [RECIP_STEP_W-1:0] RECIP_STEP = 23'd5368710;
    localparam int SHIFT_500  = 28;
    localparam int SHIFT_1000 = 29;
    localparam int PROD1_W    = FREQ_W + RECIP_STEP_W;

    // floor(y/10) = (y*RECIP_TEN) >> 20 for 16-bit y
    localparam int RECIP_TEN_W = 17;
    localparam logic [RECIP_TEN_W-1:0] RECIP_TEN = 17'd104858;
    localparam int SHIFT_TEN  = 20;
    localparam int PROD2_W    = QUOT_W + RECIP_TEN_W;
    localparam logic [QUOT_W-1:0] ROUND_HALF = 16'd5;

endpackage

`default_nettype wire

[hdl/tpws_calc.sv]
// Pipelined computation of the four PLL register words from one request.
`default_nettype none

module tpws_calc
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [tpws_pkg::FREQ_W-1:0] tune_khz,
    input  wire logic [tpws_pkg::BW_W-1:0]   bandwidth_khz,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output tpws_pkg::words_t                out_words
);

    // Stage 0: input register
    logic                        v0_reg;
    logic [tpws_pkg::FREQ_W-1:0] f_reg;
    logic [tpws_pkg::BW_W-1:0]   bw_reg;

    // Stage 1: coarse quotient and band/filter bits
    logic                        v1_reg;
    logic [tpws_pkg::QUOT_W-1:0] q_reg;
    tpws_pkg::byte_t             w3_s1_reg;
    tpws_pkg::byte_t             w4_s1_reg;
    logic                        psc_s1_reg;

    // Stage 2: rounded divider count
    logic                        v2_reg;
    logic [tpws_pkg::CNT_W-1:0]  cnt_reg;
    tpws_pkg::byte_t             w3_s2_reg;
    tpws_pkg::byte_t             w4_s2_reg;
    logic                        psc_s2_reg;

    logic rdy0, rdy1, rdy2;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    // Stage 0 -> 1 logic
    logic                          step500;
    logic                          psc, dv;
    logic [2:0]                    ba;
    logic [tpws_pkg::LPF_W-1:0]    lpf;
    logic [tpws_pkg::PROD1_W-1:0]  prod1;
    logic [tpws_pkg::QUOT_W-1:0]   q_next;
    tpws_pkg::byte_t               w3a, w3b, w3_next;
    tpws_pkg::byte_t               w4a, w4b, w4_next;

    always_comb
    begin
        step500 = f_reg < tpws_pkg::REF_SPLIT_KHZ;
        psc     = f_reg < 22'd1073000;
        dv      = f_reg < 22'd1154000;

        if      (f_reg < 22'd986000)  ba = 3'd5;
        else if (f_reg < 22'd1073000) ba = 3'd6;
        else if (f_reg < 22'd1154000) ba = 3'd7;
        else if (f_reg < 22'd1291000) ba = 3'd1;
        else if (f_reg < 22'd1447000) ba = 3'd2;
        else if (f_reg < 22'd1615000) ba = 3'd3;
        else if (f_reg < 22'd1791000) ba = 3'd4;
        else if (f_reg < 22'd1972000) ba = 3'd5;
        else                          ba = 3'd6;

        if      (bw_reg <= 16'd6000)  lpf = 4'd3;
        else if (bw_reg <= 16'd8000)  lpf = 4'd4;
        else if (bw_reg <= 16'd12000) lpf = 4'd5;
        else if (bw_reg <= 16'd16000) lpf = 4'd6;
        else if (bw_reg <= 16'd18000) lpf = 4'd7;
        else if (bw_reg <= 16'd20000) lpf = 4'd8;
        else if (bw_reg <= 16'd22000) lpf = 4'd9;
        else if (bw_reg <= 16'd24000) lpf = 4'd10;
        else if (bw_reg <= 16'd26000) lpf = 4'd11;
        else if (bw_reg <= 16'd28000) lpf = 4'd12;
        else if (bw_reg <= 16'd30000) lpf = 4'd13;
        else if (bw_reg <= 16'd32000) lpf = 4'd14;
        else                          lpf = 4'd15;

        w4a = (tpws_pkg::W4_INIT & 8'hEF) | {3'b000, psc, 4'b0000};
        w4b = (w4a & 8'h1D) | {6'b000000, dv, 1'b0} | {ba, 5'b00000};

        w3a = {tpws_pkg::W3_INIT[7:1], step500};
        w3b = w3a;
        if (f_reg < 22'd1450000)
        begin
            if (f_reg < 22'd1300000)      w3b = w3a & tpws_pkg::MASK_CP_HI;
            else if (f_reg < 22'd1375000) w3b = w3a & tpws_pkg::MASK_CP_LO;
        end
        else
        begin
            if (f_reg < 22'd1850000)      w3b = w3a & tpws_pkg::MASK_CP_HI;
            else if (f_reg < 22'd2045000) w3b = w3a & tpws_pkg::MASK_CP_LO;
        end

        w3_next = w3b;
        w4_next = w4b;
        if (bw_reg != '0)
        begin
            w3_next = (w3b & 8'hE7) | {3'b000, lpf[0], lpf[1], 3'b000};
            w4_next = (w4b & 8'hF3) | {4'b0000, lpf[2], lpf[3], 2'b00};
        end

        prod1 = tpws_pkg::PROD1_W'(f_reg) * tpws_pkg::PROD1_W'(tpws_pkg::RECIP_STEP);
        if (step500)
            q_next = prod1[tpws_pkg::SHIFT_500 +: tpws_pkg::QUOT_W];
        else
            q_next = prod1[tpws_pkg::SHIFT_1000 +: tpws_pkg::QUOT_W];
    end

    // Stage 1 -> 2 logic: round to the nearest step
    logic [tpws_pkg::QUOT_W-1:0]  y;
    logic [tpws_pkg::PROD2_W-1:0] prod2;
    logic [tpws_pkg::CNT_W-1:0]   cnt_next;

    always_comb
    begin
        y        = q_reg + tpws_pkg::ROUND_HALF;
        prod2    = tpws_pkg::PROD2_W'(y) * tpws_pkg::PROD2_W'(tpws_pkg::RECIP_TEN);
        cnt_next = prod2[tpws_pkg::SHIFT_TEN +: tpws_pkg::CNT_W];
    end

    // Stage 2 output: split into N and A, pack as (N << 5) | A
    logic [13:0] packed_na;

    always_comb
    begin
        if (psc_s2_reg)
            packed_na = {cnt_reg[12:4], 1'b0, cnt_reg[3:0]};
        else
            packed_na = {1'b0, cnt_reg};
        out_words.w1 = (tpws_pkg::W1_INIT & 8'h60) | {3'b000, packed_na[12:8]};
        out_words.w2 = packed_na[7:0];
        out_words.w3 = w3_s2_reg;
        out_words.w4 = w4_s2_reg;
    end

    assign out_valid = v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) v0_reg <= in_valid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            f_reg  <= tune_khz;
            bw_reg <= bandwidth_khz;
        end
        if (rdy1)
        begin
            q_reg      <= q_next;
            w3_s1_reg  <= w3_next;
            w4_s1_reg  <= w4_next;
            psc_s1_reg <= psc;
        end
        if (rdy2)
        begin
            cnt_reg    <= cnt_next;
            w3_s2_reg  <= w3_s1_reg;
            w4_s2_reg  <= w4_s1_reg;
            psc_s2_reg <= psc_s1_reg;
        end
    end

endmodule

`default_nettype wire

[hdl/tuner_pll_word_sequence.sv]
// Top level: tuner PLL register-word sequencer, request in, four register writes out.
//
// Input channel (s_*): one item is a tuning request, frequency and filter
// bandwidth in kHz. Output channel (m_*): one item is one register write of
// up to four bytes, with the wait it needs afterwards; m_tlast marks the
// fourth write, so every request produces a frame of exactly four items:
// VCO-wait write, TM-set byte (12 ms wait), final byte pair, w1 restore.
//
// Path: a request passes the input register, two multiply stages and then the
// write register before its first write shows on m_*.
// Throughput: one write per cycle while m_tready is high; the write sequencer
// is the limit, and the three-stage front end keeps taking requests while a
// frame is still being sent.
//
// Reset clears all valid flags and the sequencer; nothing is in flight after
// reset. When m_tready is low the current write holds on m_* and the front
// end fills up; s_tready drops only once all stages hold a request.
`default_nettype none

module tuner_pll_word_sequence
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // tune_khz[21:0], bandwidth_khz[37:22], zero[39:38]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // byte_count[2:0], data_0[10:3], data_1[18:11],
                                        // data_2[26:19], data_3[34:27], wait_after_ms[38:35],
                                        // zero[39]
    output logic             m_tlast
);

    logic             calc_valid;
    logic             calc_ready;
    tpws_pkg::words_t calc_words;

    tpws_calc u_calc
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .tune_khz      (s_tdata[21:0]),
        .bandwidth_khz (s_tdata[37:22]),
        .out_valid     (calc_valid),
        .out_ready     (calc_ready),
        .out_words     (calc_words)
    );

    // Write sequencer: hold one word set, step through the four writes
    logic             busy_reg;
    logic [1:0]       beat_reg;
    tpws_pkg::words_t words_reg;
    logic             last_taken;

    assign last_taken = busy_reg && m_tready && (beat_reg == tpws_pkg::BEAT_RESTORE);
    assign calc_ready = !busy_reg || last_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            beat_reg <= tpws_pkg::BEAT_VCO;
        end
        else if (calc_ready)
        begin
            busy_reg <= calc_valid;
            beat_reg <= tpws_pkg::BEAT_VCO;
        end
        else if (m_tready)
        begin
            beat_reg <= beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_ready)
            words_reg <= calc_words;
    end

    // Format the current write
    logic [tpws_pkg::COUNT_W-1:0] byte_count;
    tpws_pkg::byte_t              data_0, data_1, data_2, data_3;
    logic [tpws_pkg::WAIT_W-1:0]  wait_after_ms;
    logic                         last;
    tpws_pkg::byte_t              w3_clr;

    always_comb
    begin
        w3_clr        = words_reg.w3 & tpws_pkg::MASK_W3;
        byte_count    = tpws_pkg::COUNT_ONE;
        data_0        = '0;
        data_1        = '0;
        data_2        = '0;
        data_3        = '0;
        wait_after_ms = tpws_pkg::WAIT_NONE;
        last          = 1'b0;
        unique case (beat_reg)
            tpws_pkg::BEAT_VCO:
            begin
                byte_count = tpws_pkg::COUNT_FULL;
                data_0     = (words_reg.w1 & tpws_pkg::MASK_VCO_W1) | tpws_pkg::SET_VCO_W1;
                data_1     = words_reg.w2;
                data_2     = w3_clr;
                data_3     = words_reg.w4 & tpws_pkg::MASK_W4;
            end
            tpws_pkg::BEAT_TM:
            begin
                data_0        = w3_clr | tpws_pkg::TM_BIT;
                wait_after_ms = tpws_pkg::WAIT_TM_MS;
            end
            tpws_pkg::BEAT_FINAL:
            begin
                byte_count = tpws_pkg::COUNT_PAIR;
                data_0     = words_reg.w3 | tpws_pkg::TM_BIT;
                data_1     = words_reg.w4;
            end
            tpws_pkg::BEAT_RESTORE:
            begin
                data_0 = words_reg.w1;
                last   = 1'b1;
            end
            default:
            begin
                byte_count = tpws_pkg::COUNT_ONE;
            end
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = last;
    assign m_tdata  = {1'b0, wait_after_ms, data_3, data_2, data_1, data_0, byte_count};

    // A frame is never broken: a taken write that is not the last keeps valid up
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("write frame broken before its last item");

    // With no words ready when the last write goes, the output falls idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast && !calc_valid) |=> !m_tvalid)
        else $error("write emitted without a pending request");

    // Only the single-byte TM write carries the 12 ms wait
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[38:35] != tpws_pkg::WAIT_NONE)) |->
        (m_tdata[2:0] == tpws_pkg::COUNT_ONE && !m_tlast))
        else $error("wait attached to the wrong write");

endmodule

`default_nettype wire

[tb/tuner_pll_word_sequence_chk.sv]
// Checker for the tuner PLL sequencer: predicts each request's four writes and compares.
`default_nettype none

module tuner_pll_word_sequence_chk
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,   // tune_khz[21:0], bandwidth_khz[37:22], zero[39:38]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // byte_count[2:0], data_0[10:3], data_1[18:11],
                                        // data_2[26:19], data_3[34:27], wait_after_ms[38:35]
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending,
    output int               writes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [tpws_pkg::COUNT_W-1:0] count;
        tpws_pkg::byte_t              data0;
        tpws_pkg::byte_t              data1;
        tpws_pkg::byte_t              data2;
        tpws_pkg::byte_t              data3;
        logic [tpws_pkg::WAIT_W-1:0]  wait_ms;
        logic                         last;
    } reg_write_t;

    reg_write_t writes_due[$];
    reg_write_t oldest;

    function automatic int unsigned vco_band(input int unsigned f);
        if (f < 986000)  return 1;
        if (f < 1073000) return 2;
        if (f < 1154000) return 3;
        if (f < 1291000) return 4;
        if (f < 1447000) return 5;
        if (f < 1615000) return 6;
        if (f < 1791000) return 7;
        if (f < 1972000) return 8;
        return 9;
    endfunction

    // Band select bits of W4[7:5]; the code wraps around after band 3
    function automatic logic [2:0] band_bits(input int unsigned band);
        case (band)
            1:       return 3'd5;
            2:       return 3'd6;
            3:       return 3'd7;
            4:       return 3'd1;
            5:       return 3'd2;
            6:       return 3'd3;
            7:       return 3'd4;
            8:       return 3'd5;
            default: return 3'd6;
        endcase
    endfunction

    function automatic logic [tpws_pkg::LPF_W-1:0] lowpass_code(input int unsigned bw);
        if (bw <= 6000)  return 4'd3;
        if (bw <= 8000)  return 4'd4;
        if (bw <= 12000) return 4'd5;
        if (bw <= 16000) return 4'd6;
        if (bw <= 18000) return 4'd7;
        if (bw <= 20000) return 4'd8;
        if (bw <= 22000) return 4'd9;
        if (bw <= 24000) return 4'd10;
        if (bw <= 26000) return 4'd11;
        if (bw <= 28000) return 4'd12;
        if (bw <= 30000) return 4'd13;
        if (bw <= 32000) return 4'd14;
        return 4'd15;
    endfunction

    // Fold one request into the register words and queue its four writes
    function automatic void queue_sequence(input logic [tpws_pkg::FREQ_W-1:0] freq,
                                           input logic [tpws_pkg::BW_W-1:0] bw);
        tpws_pkg::byte_t            w1, w2, w3, w4, op0, op2, op3;
        int unsigned                f, band, step, cnt, pre, n, a;
        logic [31:0]                div_word;
        logic [tpws_pkg::LPF_W-1:0] lp;
        reg_write_t                 wr;

        f    = 32'(freq);
        w1   = tpws_pkg::W1_INIT;
        w3   = tpws_pkg::W3_INIT;
        w4   = tpws_pkg::W4_INIT;
        band = vco_band(f);

        w4[4]   = (band <= 2);      // prescaler
        w4[1]   = (band <= 3);      // divider
        w4[7:5] = band_bits(band);

        // Reference bit: 500 kHz step below the split, 1000 kHz at or above
        w3[0] = (f < tpws_pkg::REF_SPLIT_KHZ);

        // Charge-pump current by range
        if (f < 1450000)
        begin
            if (f < 1300000)
                w3 &= tpws_pkg::MASK_CP_HI;
            else if (f < 1375000)
                w3 &= tpws_pkg::MASK_CP_LO;
        end
        else
        begin
            if (f < 1850000)
                w3 &= tpws_pkg::MASK_CP_HI;
            else if (f < 2045000)
                w3 &= tpws_pkg::MASK_CP_LO;
        end

        step     = w3[0] ? 500 : 1000;
        cnt      = (f * 10 / step + 5) / 10;
        pre      = w4[4] ? 16 : 32;
        n        = cnt / pre;
        a        = cnt - pre * n;
        div_word = (n << 5) | a;
        w1       = (w1 & 8'h60) | {3'b000, div_word[12:8]};
        w2       = div_word[7:0];

        if (bw != 0)
        begin
            lp    = lowpass_code(32'(bw));
            w3[4] = lp[0];
            w3[3] = lp[1];
            w4[3] = lp[2];
            w4[2] = lp[3];
        end

        op0 = (w1 & tpws_pkg::MASK_VCO_W1) | tpws_pkg::SET_VCO_W1;
        op2 = w3 & tpws_pkg::MASK_W3;
        op3 = w4 & tpws_pkg::MASK_W4;

        // VCO wait write
        wr.count = tpws_pkg::COUNT_FULL; wr.data0 = op0; wr.data1 = w2; wr.data2 = op2;
        wr.data3 = op3; wr.wait_ms = tpws_pkg::WAIT_NONE; wr.last = 1'b0;
        writes_due.push_back(wr);

        // TM set, then hold 12 ms
        wr.count = tpws_pkg::COUNT_ONE; wr.data0 = op2 | tpws_pkg::TM_BIT; wr.data1 = '0;
        wr.data2 = '0; wr.data3 = '0; wr.wait_ms = tpws_pkg::WAIT_TM_MS;
        writes_due.push_back(wr);

        // Final pair
        wr.count = tpws_pkg::COUNT_PAIR; wr.data0 = w3 | tpws_pkg::TM_BIT; wr.data1 = w4;
        wr.wait_ms = tpws_pkg::WAIT_NONE;
        writes_due.push_back(wr);

        // Restore byte
        wr.count = tpws_pkg::COUNT_ONE; wr.data0 = w1; wr.data1 = '0; wr.last = 1'b1;
        writes_due.push_back(wr);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count     = 0;
            pending        = 0;
            writes_checked = 0;
            writes_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (writes_due.size() == 0)
                begin
                    $error("register write 0x%0h arrived with none outstanding", m_tdata);
                    fail_count++;
                end
                else
                begin
                    oldest = writes_due.pop_front();
                    check_field("byte_count",    32'(oldest.count),   32'(m_tdata[2:0]));
                    check_field("data_0",        32'(oldest.data0),   32'(m_tdata[10:3]));
                    check_field("data_1",        32'(oldest.data1),   32'(m_tdata[18:11]));
                    check_field("data_2",        32'(oldest.data2),   32'(m_tdata[26:19]));
                    check_field("data_3",        32'(oldest.data3),   32'(m_tdata[34:27]));
                    check_field("wait_after_ms", 32'(oldest.wait_ms), 32'(m_tdata[38:35]));
                    check_field("last",          32'(oldest.last),    32'(m_tlast));
                    writes_checked++;
                end
            end
            if (s_tvalid && s_tready)
                queue_sequence(s_tdata[21:0], s_tdata[37:22]);
            pending = writes_due.size();
        end
    end

endmodule

`default_nettype wire

[tb/tuner_pll_word_sequence_tb.sv]
// Testbench top for the tuner PLL sequencer: clock, reset, request stimulus and verdict.
`default_nettype none

module tuner_pll_word_sequence_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 340;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES   = 16;     // longer than the latency to the first write
    localparam int HOLD_AT        = 120;    // requests sent before the long stall
    localparam int HOLD_CYCLES    = 150;
    localparam int CALM_STRETCH   = 40;     // items per idling mode draw
    localparam int FREQ_MAX_KHZ   = 2500000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    logic hold_off = 1'b0;
    bit   calm_tx  = 1'b0;
    bit   calm_rx  = 1'b0;
    int   sent_count = 0;
    int   cycles     = 0;

    int fail_count;
    int pending;
    int writes_checked;

    always #5 clk = ~clk;

    tuner_pll_word_sequence u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    tuner_pll_word_sequence_chk u_chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .pending        (pending),
        .writes_checked (writes_checked)
    );

    // Lower edges of the VCO bands, the reference split and the charge-pump ranges
    function automatic int band_edge_khz(input int k);
        case (k)
            0:       return 986000;
            1:       return 1073000;
            2:       return 1154000;
            3:       return 1291000;
            4:       return 1447000;
            5:       return 1615000;
            6:       return 1791000;
            7:       return 1972000;
            8:       return 1024000;
            9:       return 1300000;
            10:      return 1375000;
            11:      return 1450000;
            12:      return 1850000;
            default: return 2045000;
        endcase
    endfunction

    // Bandwidths that hit every low-pass code and both sides of the saturation point
    function automatic int bw_probe(input int k);
        case (k)
            0:       return 0;
            1:       return 1;
            2:       return 6000;
            3:       return 6001;
            4:       return 8000;
            5:       return 12000;
            6:       return 16000;
            7:       return 18000;
            8:       return 20000;
            9:       return 22000;
            10:      return 24000;
            11:      return 26000;
            12:      return 28000;
            13:      return 30000;
            14:      return 32000;
            15:      return 32001;
            default: return 65535;
        endcase
    endfunction

    // Offer one tuning request after a random gap (none while calm_tx is set) and hold it until accepted
    task automatic send_request(input logic [tpws_pkg::FREQ_W-1:0] freq,
                                input logic [tpws_pkg::BW_W-1:0] bw);
        int gap;

        gap = calm_tx ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, bw, freq};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        sent_count++;
    endtask

    // Main stimulus: reset, directed edges, random requests, drain and verdict
    initial
    begin
        int i;
        int f;
        int bw;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Range extremes and the lowest frequency of every band / pump / reference range
        send_request(22'(0), 16'(bw_probe(0)));
        send_request(22'(FREQ_MAX_KHZ), 16'(bw_probe(16)));
        send_request(22'(2097152), 16'(bw_probe(1)));
        send_request(22'(985999), 16'(bw_probe(2)));
        send_request(22'(1023999), 16'(bw_probe(3)));
        for (i = 0; i < 14; i++)
            send_request(22'(band_edge_khz(i)), 16'(bw_probe((i + 4) % 17)));

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Switch idling on and off in stretches
            if (i % CALM_STRETCH == 0)
                calm_tx = ($urandom_range(0, 3) == 0);

            case ($urandom_range(0, 3))
                0, 1:    f = $urandom_range(0, FREQ_MAX_KHZ);
                2:       f = band_edge_khz($urandom_range(0, 13)) + $urandom_range(0, 3) - 2;
                default: f = $urandom_range(0, 1023999);
            endcase

            case ($urandom_range(0, 3))
                0:       bw = 0;
                1:       bw = $urandom_range(1, 33000);
                2:       bw = $urandom_range(0, 65535);
                default: bw = bw_probe($urandom_range(0, 16)) + $urandom_range(0, 1);
            endcase

            send_request(22'(f), 16'(bw));
        end
        s_tvalid <= 1'b0;
        // Let the checker queue the last request before its pending count is read
        @(posedge clk);

        // Let every predicted write come out, then watch for strays
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d tuning requests (range edges, then random)", sent_count);
        $display("and %0d register writes, with random gaps and one %0d-cycle receiver stall",
                 writes_checked, HOLD_CYCLES);
        if (fail_count == 0)
            $display("[tuner_pll_word_sequence] OK");
        else
            $display("[tuner_pll_word_sequence] ERROR");
        $finish;
    end

    // Receiver: random stall before each write (none while calm_rx is set), plus the long hold-off
    initial
    begin
        int stall;
        int taken;

        taken = 0;
        wait (rst_n);
        forever
        begin
            if (taken % CALM_STRETCH == 0)
                calm_rx = ($urandom_range(0, 3) == 0);
            stall = calm_rx ? 0 : $urandom_range(0, 7);
            if (stall > 0 || hold_off)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (hold_off)
                    @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    // Long hold-off: stop draining so the front end fills and backs up the requests
    initial
    begin
        while (sent_count < HOLD_AT)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog
    initial
    begin
        while (cycles < TIMEOUT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[tuner_pll_word_sequence] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
